// File: design/ptt_pkg.sv
// shared types and constants for the periodic task timer
// used by periodic_task_timer_groups_core and the bench; no dependencies
package ptt_pkg;

    // field widths
    localparam int ID_W        = 16;
    localparam int PER_W       = 16;
    localparam int TICK_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int REQ_W       = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;
    localparam int RES_CNT_W   = 7;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_REGISTER   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UNREGISTER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK       = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_FIRED          = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ACCEPTED       = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_TASK_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_GROUP_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_PERIOD_UNKNOWN = 3'd4;

    // limits
    localparam logic [TICK_W-1:0]    TICK_MAX = 3'd4;
    localparam logic [RES_CNT_W-1:0] RES_CAP  = 7'd64;

    typedef struct packed {
        logic [PER_W-1:0] period;
        logic [PER_W-1:0] counter;
    } group_entry_t;

    typedef struct packed {
        logic [ID_W-1:0]  ident;
        logic [PER_W-1:0] period;
    } task_entry_t;

endpackage

// File: design/ptt_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no package dependencies
module ptt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/periodic_task_timer_groups_core.sv
// periodic task timer core: sequencer over a group ram and a task ram
// depends on ptt_pkg and ptt_ram
//
// usage
//   s_ channel carries one request item: s_tuser is the request kind
//   (register, unregister, tick), s_tdata holds task id, period and tick count.
//   m_ channel returns result items: status and fired task id in m_tdata,
//   m_tlast marks the final result of a request.
//   register and unregister give exactly one result; a tick gives one result
//   per fired task (at most 64) or none when nothing fires.
// timing
//   one request at a time; s_tready is high only while the sequencer is idle.
//   every ram step is a read, then a use of the registered data. register
//   searches the group table by period, then shifts later groups up for a sorted
//   insert if the period is new, and appends the task; unregister searches, then
//   compacts the task table in place; a tick makes one pass over the groups per
//   elapsed tick, plus a scan of the task table for each group that fires.
//   the ram steps are strictly ordered, so a read never overlaps a write to
//   the same entry and no forwarding is required.
// reset
//   group and task counts clear, so both tables read as empty; ram contents
//   are left as is. no clearing pass.
// stall
//   one output register decouples the result side; a tick keeps the newest
//   fired id in a hold register so the last one can be flagged, and the
//   sequencer waits while the output register is full and not taken.
module periodic_task_timer_groups_core #(
    parameter int GROUPS = 8,
    parameter int TASKS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // [15:0] task_id, [31:16] period, [34:32] tick_count
    input  logic [ptt_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [ptt_pkg::REQ_W-1:0]     s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] status, [18:3] fired_task
    output logic [ptt_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    // address and count widths
    localparam int GA = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int GC = $clog2(GROUPS + 1);
    localparam int TA = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int TC = $clog2(TASKS + 1);
    localparam logic [GC-1:0] GROUPS_FULL = GC'(GROUPS);
    localparam logic [TC-1:0] TASKS_FULL  = TC'(TASKS);

    // sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_GFIND_RD  = 4'd1;
    localparam logic [3:0] ST_GFIND_CMP = 4'd2;
    localparam logic [3:0] ST_GDECIDE   = 4'd3;
    localparam logic [3:0] ST_GSH_RD    = 4'd4;
    localparam logic [3:0] ST_GSH_WR    = 4'd5;
    localparam logic [3:0] ST_TAPPEND   = 4'd6;
    localparam logic [3:0] ST_RESP      = 4'd7;
    localparam logic [3:0] ST_UN_RD     = 4'd8;
    localparam logic [3:0] ST_UN_CHK    = 4'd9;
    localparam logic [3:0] ST_TK_RD     = 4'd10;
    localparam logic [3:0] ST_TK_UPD    = 4'd11;
    localparam logic [3:0] ST_TS_RD     = 4'd12;
    localparam logic [3:0] ST_TS_CMP    = 4'd13;
    localparam logic [3:0] ST_FINISH    = 4'd14;

    // input field views
    logic [ptt_pkg::ID_W-1:0]   s_task_id;
    logic [ptt_pkg::PER_W-1:0]  s_period;
    logic [ptt_pkg::TICK_W-1:0] s_tick;
    logic [ptt_pkg::TICK_W-1:0] s_tick_sat;

    assign s_task_id  = s_tdata[15:0];
    assign s_period   = s_tdata[31:16];
    assign s_tick     = s_tdata[34:32];
    assign s_tick_sat = (s_tick > ptt_pkg::TICK_MAX) ? ptt_pkg::TICK_MAX : s_tick;

    // control state
    logic [3:0]                     state_reg, state_next;
    logic [GC-1:0]                  gcount_reg, gcount_next;
    logic [TC-1:0]                  tcount_reg, tcount_next;
    logic                           hold_valid_reg, hold_valid_next;
    logic                           m_tvalid_reg, m_tvalid_next;

    // working registers
    logic [ptt_pkg::REQ_W-1:0]      op_reg, op_next;
    logic [ptt_pkg::ID_W-1:0]       id_reg, id_next;
    logic [ptt_pkg::PER_W-1:0]      per_reg, per_next;
    logic [ptt_pkg::TICK_W-1:0]     ticks_reg, ticks_next;
    logic [GC-1:0]                  gidx_reg, gidx_next;
    logic [GC-1:0]                  sidx_reg, sidx_next;
    logic [TC-1:0]                  tidx_reg, tidx_next;
    logic [TC-1:0]                  widx_reg, widx_next;
    logic [ptt_pkg::PER_W-1:0]      cur_per_reg, cur_per_next;
    logic                           found_reg, found_next;
    logic [ptt_pkg::ID_W-1:0]       hold_id_reg, hold_id_next;
    logic [ptt_pkg::RES_CNT_W-1:0]  k_reg, k_next;
    logic [ptt_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [ptt_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [ptt_pkg::ID_W-1:0]       m_fired_reg, m_fired_next;
    logic                           m_last_reg, m_last_next;

    // output register load
    logic                           out_free;
    logic                           out_load;
    logic [ptt_pkg::STATUS_W-1:0]   out_status;
    logic [ptt_pkg::ID_W-1:0]       out_fired;
    logic                           out_last;

    // group ram port
    logic                           g_wr_en, g_rd_en;
    logic [GA-1:0]                  g_wr_addr, g_rd_addr;
    ptt_pkg::group_entry_t          g_wr_data, g_rd_data;
    logic [GC-1:0]                  sidx_m1;

    // task ram port
    logic                           t_wr_en, t_rd_en;
    logic [TA-1:0]                  t_wr_addr, t_rd_addr;
    ptt_pkg::task_entry_t           t_wr_data, t_rd_data;

    assign out_free = !m_tvalid_reg || m_tready;
    assign sidx_m1  = sidx_reg - GC'(1);

    ptt_ram #(
        .WIDTH ($bits(ptt_pkg::group_entry_t)),
        .DEPTH (GROUPS)
    ) u_group_ram (
        .aclk    (aclk),
        .wr_en   (g_wr_en),
        .wr_addr (g_wr_addr),
        .wr_data (g_wr_data),
        .rd_en   (g_rd_en),
        .rd_addr (g_rd_addr),
        .rd_data (g_rd_data)
    );

    ptt_ram #(
        .WIDTH ($bits(ptt_pkg::task_entry_t)),
        .DEPTH (TASKS)
    ) u_task_ram (
        .aclk    (aclk),
        .wr_en   (t_wr_en),
        .wr_addr (t_wr_addr),
        .wr_data (t_wr_data),
        .rd_en   (t_rd_en),
        .rd_addr (t_rd_addr),
        .rd_data (t_rd_data)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        gcount_next     = gcount_reg;
        tcount_next     = tcount_reg;
        hold_valid_next = hold_valid_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        per_next        = per_reg;
        ticks_next      = ticks_reg;
        gidx_next       = gidx_reg;
        sidx_next       = sidx_reg;
        tidx_next       = tidx_reg;
        widx_next       = widx_reg;
        cur_per_next    = cur_per_reg;
        found_next      = found_reg;
        hold_id_next    = hold_id_reg;
        k_next          = k_reg;
        status_next     = status_reg;

        g_wr_en   = 1'b0;
        g_wr_addr = gidx_reg[GA-1:0];
        g_wr_data = g_rd_data;
        g_rd_en   = 1'b0;
        g_rd_addr = gidx_reg[GA-1:0];
        t_wr_en   = 1'b0;
        t_wr_addr = widx_reg[TA-1:0];
        t_wr_data = t_rd_data;
        t_rd_en   = 1'b0;
        t_rd_addr = tidx_reg[TA-1:0];

        out_load   = 1'b0;
        out_status = ptt_pkg::STAT_FIRED;
        out_fired  = '0;
        out_last   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_tuser;
                    id_next         = s_task_id;
                    per_next        = s_period;
                    gidx_next       = '0;
                    k_next          = '0;
                    hold_valid_next = 1'b0;
                    case (s_tuser)
                        ptt_pkg::REQ_REGISTER: begin
                            if (tcount_reg == TASKS_FULL) begin
                                status_next = ptt_pkg::STAT_TASK_FULL;
                                state_next  = ST_RESP;
                            end else begin
                                state_next = ST_GFIND_RD;
                            end
                        end
                        ptt_pkg::REQ_UNREGISTER: begin
                            state_next = ST_GFIND_RD;
                        end
                        ptt_pkg::REQ_TICK: begin
                            ticks_next = s_tick_sat;
                            state_next = (s_tick_sat == '0) ? ST_FINISH : ST_TK_RD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // search the sorted group table for the period
            ST_GFIND_RD: begin
                if (gidx_reg == gcount_reg) begin
                    found_next = 1'b0;
                    state_next = ST_GDECIDE;
                end else begin
                    g_rd_en    = 1'b1;
                    state_next = ST_GFIND_CMP;
                end
            end

            ST_GFIND_CMP: begin
                if (g_rd_data.period == per_reg) begin
                    found_next = 1'b1;
                    state_next = ST_GDECIDE;
                end else if (g_rd_data.period > per_reg) begin
                    found_next = 1'b0;
                    state_next = ST_GDECIDE;
                end else begin
                    gidx_next  = gidx_reg + GC'(1);
                    state_next = ST_GFIND_RD;
                end
            end

            ST_GDECIDE: begin
                if (op_reg == ptt_pkg::REQ_UNREGISTER) begin
                    if (!found_reg) begin
                        status_next = ptt_pkg::STAT_PERIOD_UNKNOWN;
                        state_next  = ST_RESP;
                    end else begin
                        tidx_next  = '0;
                        widx_next  = '0;
                        state_next = ST_UN_RD;
                    end
                end else if (found_reg) begin
                    state_next = ST_TAPPEND;
                end else if (gcount_reg == GROUPS_FULL) begin
                    status_next = ptt_pkg::STAT_GROUP_FULL;
                    state_next  = ST_RESP;
                end else begin
                    sidx_next  = gcount_reg;
                    state_next = ST_GSH_RD;
                end
            end

            // open a slot at gidx by moving later groups up one entry
            ST_GSH_RD: begin
                if (sidx_reg == gidx_reg) begin
                    g_wr_en           = 1'b1;
                    g_wr_addr         = gidx_reg[GA-1:0];
                    g_wr_data.period  = per_reg;
                    g_wr_data.counter = per_reg;
                    gcount_next       = gcount_reg + GC'(1);
                    state_next        = ST_TAPPEND;
                end else begin
                    g_rd_en    = 1'b1;
                    g_rd_addr  = sidx_m1[GA-1:0];
                    state_next = ST_GSH_WR;
                end
            end

            ST_GSH_WR: begin
                g_wr_en    = 1'b1;
                g_wr_addr  = sidx_reg[GA-1:0];
                g_wr_data  = g_rd_data;
                sidx_next  = sidx_m1;
                state_next = ST_GSH_RD;
            end

            ST_TAPPEND: begin
                t_wr_en          = 1'b1;
                t_wr_addr        = tcount_reg[TA-1:0];
                t_wr_data.ident  = id_reg;
                t_wr_data.period = per_reg;
                tcount_next      = tcount_reg + TC'(1);
                status_next      = ptt_pkg::STAT_ACCEPTED;
                state_next       = ST_RESP;
            end

            ST_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = status_reg;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // compaction: keep entries that do not match, in order
            ST_UN_RD: begin
                if (tidx_reg == tcount_reg) begin
                    tcount_next = widx_reg;
                    status_next = ptt_pkg::STAT_ACCEPTED;
                    state_next  = ST_RESP;
                end else begin
                    t_rd_en    = 1'b1;
                    state_next = ST_UN_CHK;
                end
            end

            ST_UN_CHK: begin
                if (!(t_rd_data.ident == id_reg && t_rd_data.period == per_reg)) begin
                    t_wr_en   = 1'b1;
                    t_wr_addr = widx_reg[TA-1:0];
                    t_wr_data = t_rd_data;
                    widx_next = widx_reg + TC'(1);
                end
                tidx_next  = tidx_reg + TC'(1);
                state_next = ST_UN_RD;
            end

            // one pass over the groups per elapsed tick
            ST_TK_RD: begin
                if (gidx_reg == gcount_reg) begin
                    ticks_next = ticks_reg - ptt_pkg::TICK_W'(1);
                    gidx_next  = '0;
                    if (ticks_reg == ptt_pkg::TICK_W'(1)) begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    g_rd_en    = 1'b1;
                    state_next = ST_TK_UPD;
                end
            end

            ST_TK_UPD: begin
                g_wr_en          = 1'b1;
                g_wr_addr        = gidx_reg[GA-1:0];
                g_wr_data.period = g_rd_data.period;
                if (g_rd_data.counter <= ptt_pkg::PER_W'(1)) begin
                    g_wr_data.counter = g_rd_data.period;
                    cur_per_next      = g_rd_data.period;
                    tidx_next         = '0;
                    state_next        = ST_TS_RD;
                end else begin
                    g_wr_data.counter = g_rd_data.counter - ptt_pkg::PER_W'(1);
                    gidx_next         = gidx_reg + GC'(1);
                    state_next        = ST_TK_RD;
                end
            end

            // emit the tasks of a firing group in insertion order
            ST_TS_RD: begin
                if (tidx_reg == tcount_reg) begin
                    gidx_next  = gidx_reg + GC'(1);
                    state_next = ST_TK_RD;
                end else begin
                    t_rd_en    = 1'b1;
                    state_next = ST_TS_CMP;
                end
            end

            ST_TS_CMP: begin
                if (t_rd_data.period == cur_per_reg && k_reg < ptt_pkg::RES_CAP) begin
                    if (!hold_valid_reg || out_free) begin
                        if (hold_valid_reg) begin
                            out_load  = 1'b1;
                            out_fired = hold_id_reg;
                        end
                        hold_id_next    = t_rd_data.ident;
                        hold_valid_next = 1'b1;
                        k_next          = k_reg + ptt_pkg::RES_CNT_W'(1);
                        tidx_next       = tidx_reg + TC'(1);
                        state_next      = ST_TS_RD;
                    end
                end else begin
                    tidx_next  = tidx_reg + TC'(1);
                    state_next = ST_TS_RD;
                end
            end

            // flush the held result with the last flag
            ST_FINISH: begin
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    out_fired       = hold_id_reg;
                    out_last        = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_fired_next  = m_fired_reg;
        m_last_next   = m_last_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_status_next = out_status;
            m_fired_next  = out_fired;
            m_last_next   = out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            gcount_reg     <= '0;
            tcount_reg     <= '0;
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            k_reg          <= '0;
        end else begin
            state_reg      <= state_next;
            gcount_reg     <= gcount_next;
            tcount_reg     <= tcount_next;
            hold_valid_reg <= hold_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            k_reg          <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        per_reg      <= per_next;
        ticks_reg    <= ticks_next;
        gidx_reg     <= gidx_next;
        sidx_reg     <= sidx_next;
        tidx_reg     <= tidx_next;
        widx_reg     <= widx_next;
        cur_per_reg  <= cur_per_next;
        found_reg    <= found_next;
        hold_id_reg  <= hold_id_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_fired_reg  <= m_fired_next;
        m_last_reg   <= m_last_next;
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'b0, m_fired_reg, m_status_reg};

    // checks
    a_gcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        gcount_reg <= GROUPS_FULL)
        else $error("group count above table size");

    a_tcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tcount_reg <= TASKS_FULL)
        else $error("task count above table size");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("output register loaded while holding an untaken item");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held fired result left behind at idle");

    a_res_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= ptt_pkg::RES_CAP)
        else $error("fired result count above cap");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking bench for periodic_task_timer_groups_core: register, unregister and tick items
// are predicted by a behavioral copy of the group and task tables; depends on ptt_pkg
module tb;

    localparam int NGROUPS        = 8;
    localparam int NTASKS         = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RUN_CAP        = 2000000;
    localparam int END_CYCLES     = 300;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 205;
    localparam int TAIL_ITEMS     = 40;
    localparam int ERROR_PRINTS   = 40;

    // request kind the block has no use for
    localparam logic [ptt_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;

    typedef struct packed {
        logic [ptt_pkg::REQ_W-1:0]  kind;
        logic [ptt_pkg::ID_W-1:0]   ident;
        logic [ptt_pkg::PER_W-1:0]  period;
        logic [ptt_pkg::TICK_W-1:0] ticks;
        logic                       drain;   // hold this item back until all results are in
    } request_t;

    typedef struct packed {
        logic [ptt_pkg::STATUS_W-1:0] status;
        logic [ptt_pkg::ID_W-1:0]     fired;
        logic                         last;
    } outcome_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic [ptt_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [ptt_pkg::REQ_W-1:0]     s_tuser  = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ptt_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;

    always #4 aclk = ~aclk;

    periodic_task_timer_groups_core #(
        .GROUPS (NGROUPS),
        .TASKS  (NTASKS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // bench state shared between processes
    request_t pending[$];          // items not yet offered
    outcome_t outcome_q[$];        // results owed by the block, oldest first
    request_t in_flight;
    int       n_predicted    = 0;  // results predicted so far (driver side)
    int       n_results_seen = 0;  // results taken so far (monitor side, nonblocking)
    int       n_errors       = 0;
    logic     quiet_tail     = 1'b0;

    // mirror of the timer tables
    bit                        grp_used [NGROUPS];
    logic [ptt_pkg::PER_W-1:0] grp_per  [NGROUPS];
    logic [ptt_pkg::PER_W-1:0] grp_cnt  [NGROUPS];
    bit                        tsk_used [NTASKS];
    logic [ptt_pkg::ID_W-1:0]  tsk_id   [NTASKS];
    logic [ptt_pkg::PER_W-1:0] tsk_per  [NTASKS];

    // valid tasks always form a prefix of the table
    function automatic int live_tasks();
        int n = 0;
        while (n < NTASKS && tsk_used[n])
            n++;
        return n;
    endfunction

    function automatic int group_of(logic [ptt_pkg::PER_W-1:0] p);
        for (int g = 0; g < NGROUPS; g++)
            if (grp_used[g] && grp_per[g] == p)
                return g;
        return -1;
    endfunction

    // apply one accepted item to the mirror and queue the results it owes
    task automatic timer_apply(request_t rq);
        int                           n;
        int                           g;
        int                           w;
        int                           best;
        int                           nt;
        logic [ptt_pkg::STATUS_W-1:0] st;
        logic [ptt_pkg::PER_W-1:0]    prev_per;
        bit                           seen_any;
        outcome_t                     fires[$];
        outcome_t                     o;
        n = live_tasks();
        o.fired = '0;
        o.last  = 1'b1;
        case (rq.kind)
            ptt_pkg::REQ_REGISTER: begin
                // task table is checked before the group table
                st = ptt_pkg::STAT_ACCEPTED;
                if (n >= NTASKS) begin
                    st = ptt_pkg::STAT_TASK_FULL;
                end else if (group_of(rq.period) < 0) begin
                    g = 0;
                    while (g < NGROUPS && grp_used[g])
                        g++;
                    if (g >= NGROUPS) begin
                        st = ptt_pkg::STAT_GROUP_FULL;
                    end else begin
                        // new group starts at the full period
                        grp_used[g] = 1'b1;
                        grp_per[g]  = rq.period;
                        grp_cnt[g]  = rq.period;
                    end
                end
                if (st == ptt_pkg::STAT_ACCEPTED) begin
                    tsk_used[n] = 1'b1;
                    tsk_id[n]   = rq.ident;
                    tsk_per[n]  = rq.period;
                end
                o.status = st;
                outcome_q = {outcome_q, o};
                n_predicted++;
            end
            ptt_pkg::REQ_UNREGISTER: begin
                if (group_of(rq.period) < 0) begin
                    o.status = ptt_pkg::STAT_PERIOD_UNKNOWN;
                end else begin
                    // compact the table, dropping every matching entry
                    w = 0;
                    for (int r = 0; r < n; r++) begin
                        if (!(tsk_id[r] == rq.ident && tsk_per[r] == rq.period)) begin
                            tsk_id[w]  = tsk_id[r];
                            tsk_per[w] = tsk_per[r];
                            w++;
                        end
                    end
                    for (int r = w; r < NTASKS; r++)
                        tsk_used[r] = 1'b0;
                    o.status = ptt_pkg::STAT_ACCEPTED;
                end
                outcome_q = {outcome_q, o};
                n_predicted++;
            end
            ptt_pkg::REQ_TICK: begin
                nt = (rq.ticks > ptt_pkg::TICK_MAX) ? ptt_pkg::TICK_MAX : rq.ticks;
                for (int k = 0; k < nt; k++) begin
                    seen_any = 1'b0;
                    prev_per = '0;
                    best     = 0;
                    // visit groups in ascending period order
                    while (best >= 0) begin
                        best = -1;
                        for (int i = 0; i < NGROUPS; i++) begin
                            if (grp_used[i] && !(seen_any && grp_per[i] <= prev_per) &&
                                (best < 0 || grp_per[i] < grp_per[best]))
                                best = i;
                        end
                        if (best >= 0) begin
                            seen_any = 1'b1;
                            prev_per = grp_per[best];
                            if (grp_cnt[best] <= 1) begin
                                grp_cnt[best] = grp_per[best];
                                for (int i = 0; i < n; i++) begin
                                    if (tsk_per[i] == grp_per[best] &&
                                        fires.size() < ptt_pkg::RES_CAP) begin
                                        o.status = ptt_pkg::STAT_FIRED;
                                        o.fired  = tsk_id[i];
                                        o.last   = 1'b0;
                                        fires    = {fires, o};
                                    end
                                end
                            end else begin
                                grp_cnt[best] = grp_cnt[best] - 1'b1;
                            end
                        end
                    end
                end
                if (fires.size() > 0)
                    fires[fires.size() - 1].last = 1'b1;
                foreach (fires[i]) begin
                    outcome_q = {outcome_q, fires[i]};
                    n_predicted++;
                end
            end
            default: begin
                // spare kind: ignored, no result
            end
        endcase
    endtask

    function automatic void add_req(logic [ptt_pkg::REQ_W-1:0] k,
                                    logic [ptt_pkg::ID_W-1:0] id,
                                    logic [ptt_pkg::PER_W-1:0] p,
                                    logic [ptt_pkg::TICK_W-1:0] t, bit d);
        request_t rq;
        rq.kind   = k;
        rq.ident  = id;
        rq.period = p;
        rq.ticks  = t;
        rq.drain  = d;
        pending = {pending, rq};
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            if (n_errors < ERROR_PRINTS)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // driver: offers queued items, predicts each one at its acceptance
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                timer_apply(in_flight);
            quiet_tail <= (pending.size() <= TAIL_ITEMS);
            if (s_tvalid && !s_tready) begin
                // item still on offer, keep it
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending[0].drain && n_results_seen != n_predicted) begin
                // sender pause: let every owed result come back first
                s_tvalid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < 10) begin
                gap_left = $urandom_range(0, 13);
                s_tvalid <= 1'b0;
            end else begin
                in_flight = pending.pop_front();
                s_tdata   <= {5'b0, in_flight.ticks, in_flight.period, in_flight.ident};
                s_tuser   <= in_flight.kind;
                s_tvalid  <= 1'b1;
            end
        end
    end

    // monitor: takes results, checks them in order, throttles m_tready
    int hold_left      = 0;
    bit long_hold_done = 1'b0;
    outcome_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results_seen <= n_results_seen + 1;
                if (outcome_q.size() == 0) begin
                    if (n_errors < ERROR_PRINTS)
                        $display("%0t: unexpected result, expected none actual status %0d task %0h",
                                 $time, m_tdata[2:0], m_tdata[18:3]);
                    n_errors++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", want.status, m_tdata[2:0]);
                    check_field("fired_task", want.fired, m_tdata[18:3]);
                    check_field("last", want.last, m_tlast);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && !quiet_tail && n_results_seen >= 80 &&
                         outcome_q.size() >= 3) begin
                // long back-pressure while a multi-result tick is owed, so the input stalls
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < 10) begin
                hold_left = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on handshake activity plus an overall cap
    int idle_cycles = 0;
    int run_cycles  = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            run_cycles++;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT || run_cycles >= RUN_CAP) begin
                $display("%0t: timeout", $time);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // stimulus and end of run
    logic [ptt_pkg::REQ_W-1:0]  r_kind;
    logic [ptt_pkg::ID_W-1:0]   r_id;
    logic [ptt_pkg::PER_W-1:0]  r_per;
    logic [ptt_pkg::TICK_W-1:0] r_ticks;
    int                         pick;

    initial begin
        // tick on empty tables: nothing fires
        add_req(ptt_pkg::REQ_TICK, 16'h0000, 16'h0000, 3'd4, 1'b0);
        // eight groups, created out of period order, extremes of the period field
        add_req(ptt_pkg::REQ_REGISTER, 16'h0001, 16'd3, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h0002, 16'd0, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'hFFFF, 16'hFFFF, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h0003, 16'd1, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h0004, 16'd2, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h0005, 16'hAAAA, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h0006, 16'd6, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h0007, 16'd4, 3'd0, 1'b0);
        // ninth period: group table full
        add_req(ptt_pkg::REQ_REGISTER, 16'h0008, 16'h5555, 3'd0, 1'b0);
        // join existing groups, including duplicate id/period pairs
        add_req(ptt_pkg::REQ_REGISTER, 16'h0002, 16'd0, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h0003, 16'd1, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h8000, 16'd1, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h1234, 16'd2, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h0001, 16'd3, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h4321, 16'd0, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h0009, 16'd4, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_REGISTER, 16'h000A, 16'd6, 3'd0, 1'b0);
        // task table full wins over a new period
        add_req(ptt_pkg::REQ_REGISTER, 16'h000B, 16'h7777, 3'd0, 1'b0);
        // tick count above four saturates, zero gives nothing, spare kind ignored
        add_req(ptt_pkg::REQ_TICK, 16'h0000, 16'h0000, 3'd7, 1'b0);
        add_req(ptt_pkg::REQ_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0);
        add_req(REQ_SPARE, 16'h0002, 16'd0, 3'd1, 1'b0);
        // removal of duplicates, removal with no match, unknown period
        add_req(ptt_pkg::REQ_UNREGISTER, 16'h0002, 16'd0, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_UNREGISTER, 16'h0002, 16'd0, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_UNREGISTER, 16'h0001, 16'h5555, 3'd0, 1'b0);
        add_req(ptt_pkg::REQ_TICK, 16'h0000, 16'h0000, 3'd1, 1'b0);
        add_req(ptt_pkg::REQ_TICK, 16'h0000, 16'h0000, 3'd5, 1'b0);

        // random part: mostly known periods and a small id pool so tasks match and fire
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                r_kind = ptt_pkg::REQ_REGISTER;
            else if (pick < 58)
                r_kind = ptt_pkg::REQ_UNREGISTER;
            else if (pick < 95)
                r_kind = ptt_pkg::REQ_TICK;
            else
                r_kind = REQ_SPARE;
            if ($urandom_range(0, 3) == 0)
                r_id = $urandom;
            else
                r_id = $urandom_range(0, 15);
            if ($urandom_range(0, 99) < 15) begin
                r_per = $urandom;
            end else begin
                case ($urandom_range(0, 7))
                    0: r_per = 16'd0;
                    1: r_per = 16'd1;
                    2: r_per = 16'd2;
                    3: r_per = 16'd3;
                    4: r_per = 16'd4;
                    5: r_per = 16'd6;
                    6: r_per = 16'hAAAA;
                    default: r_per = 16'hFFFF;
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                r_ticks = $urandom_range(0, 7);
            else
                r_ticks = $urandom_range(1, 4);
            add_req(r_kind, r_id, r_per, r_ticks, (i == 0 || i == RANDOM_ITEMS / 2));
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(posedge aclk);
        while (pending.size() != 0 || s_tvalid || n_results_seen < n_predicted);
        // room for a trailing item that owes no result
        repeat (END_CYCLES) @(posedge aclk);

        if (outcome_q.size() != 0) begin
            $display("%0t: %0d results missing, first expected status %0d task %0h",
                     $time, outcome_q.size(), outcome_q[0].status, outcome_q[0].fired);
            n_errors++;
        end
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
